[rtl/core/ptf_pkg.sv]
// shared types and token codes for the pd transmit fifo token framer
`default_nettype none
package ptf_pkg;

	localparam int OBJ_SLOTS = 7;

	localparam logic [7:0] TOK_SOP1    = 8'h12;
	localparam logic [7:0] TOK_SOP2    = 8'h13;
	localparam logic [7:0] TOK_PACKSYM = 8'h80;
	localparam logic [7:0] TOK_JAM_CRC = 8'hFF;
	localparam logic [7:0] TOK_EOP     = 8'h14;
	localparam logic [7:0] TOK_TXOFF   = 8'hFE;
	localparam logic [7:0] TOK_TXON    = 8'hA1;

	// fixed frame layout: four sop tokens, packsym, two header bytes
	localparam logic [5:0] POS_PACKSYM = 6'd4;
	localparam logic [5:0] POS_HDR_LO  = 6'd5;
	localparam logic [5:0] POS_HDR_HI  = 6'd6;
	localparam logic [5:0] POS_OBJ     = 6'd7;

	typedef logic [OBJ_SLOTS-1:0][31:0] obj_arr_t;

	typedef struct packed {
		logic       vld;
		logic       last;
		logic [7:0] data;
	} cell_t;

	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctl_t;

endpackage
`default_nettype wire

[rtl/core/ptf_msg_if.sv]
// message request channel: header, object count and data objects
`default_nettype none
interface ptf_msg_if;
	logic        valid;
	logic        ready;
	logic [15:0] header;
	logic [2:0]  num_objs;
	logic [31:0] data_object_0;
	logic [31:0] data_object_1;
	logic [31:0] data_object_2;
	logic [31:0] data_object_3;
	logic [31:0] data_object_4;
	logic [31:0] data_object_5;
	logic [31:0] data_object_6;

	modport source (
		output valid, header, num_objs, data_object_0, data_object_1, data_object_2,
		       data_object_3, data_object_4, data_object_5, data_object_6,
		input  ready
	);
	modport sink (
		input  valid, header, num_objs, data_object_0, data_object_1, data_object_2,
		       data_object_3, data_object_4, data_object_5, data_object_6,
		output ready
	);
endinterface
`default_nettype wire

[rtl/core/ptf_byte_if.sv]
// fifo byte request channel: one token or payload byte with last marker
`default_nettype none
interface ptf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] tok_byte;
	logic       last_byte;

	modport source (output valid, tok_byte, last_byte, input ready);
	modport sink (input valid, tok_byte, last_byte, output ready);
endinterface
`default_nettype wire

[rtl/core/ptf_cell.sv]
// one byte cell of the frame shift chain: loads its frame byte, then shifts toward the head
`default_nettype none
module ptf_cell #(
	parameter int IDX = 0
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire ptf_pkg::cell_ctl_t ctl,
	input  wire [15:0]              header,
	input  wire [2:0]               cnt,
	input  wire ptf_pkg::obj_arr_t  objs,
	input  wire ptf_pkg::cell_t     from_next,
	output ptf_pkg::cell_t          cell_out
);
	import ptf_pkg::*;

	localparam logic [5:0] POS = 6'(IDX);

	logic [5:0]  tail;
	logic [5:0]  rel;
	logic [2:0]  osel;
	logic [31:0] word;
	cell_t       ld;
	logic        vld_q;
	logic        last_q;
	logic [7:0]  data_q;

	always_comb begin
		tail = POS_OBJ + {1'b0, cnt, 2'b00};
		rel  = POS - POS_OBJ;
		osel = rel[4:2];
		word = (osel < 3'(OBJ_SLOTS)) ? objs[osel] : 32'd0;
		ld.vld  = (POS <= tail + 6'd3);
		ld.last = (POS == tail + 6'd3);
		if (POS < POS_PACKSYM) begin
			ld.data = (POS == 6'd3) ? TOK_SOP2 : TOK_SOP1;
		end else if (POS == POS_PACKSYM) begin
			ld.data = TOK_PACKSYM | {3'b000, cnt, 2'b10};
		end else if (POS == POS_HDR_LO) begin
			ld.data = header[7:0];
		end else if (POS == POS_HDR_HI) begin
			ld.data = header[15:8];
		end else if (POS < tail) begin
			ld.data = word[{rel[1:0], 3'b000} +: 8];
		end else if (POS == tail) begin
			ld.data = TOK_JAM_CRC;
		end else if (POS == tail + 6'd1) begin
			ld.data = TOK_EOP;
		end else if (POS == tail + 6'd2) begin
			ld.data = TOK_TXOFF;
		end else begin
			ld.data = TOK_TXON;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.load) begin
			vld_q <= ld.vld;
		end else if (ctl.shift) begin
			vld_q <= from_next.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			last_q <= ld.last;
			data_q <= ld.data;
		end else if (ctl.shift) begin
			last_q <= from_next.last;
			data_q <= from_next.data;
		end
	end

	assign cell_out.vld  = vld_q;
	assign cell_out.last = last_q;
	assign cell_out.data = data_q;

endmodule
`default_nettype wire

[rtl/core/pd_tx_fifo_token_framer.sv]
// top level: usb pd message to transmit fifo token stream over a chain of byte cells
//
//  channel | dir | payload                                  | accepted when
//  msg     | in  | header, num_objs, data_object_0..6       | msg.valid && msg.ready
//  tx      | out | tok_byte, last_byte                      | tx.valid && tx.ready
//
// a message loads all 11+4n frame bytes into the cell chain in a single load
// bytes leave from the head cell one per cycle while tx.ready is high
// a new message is taken once the chain is empty, the cycle after txon leaves
// reset clears the cell valid bits; tx stalls just hold the chain
`default_nettype none
module pd_tx_fifo_token_framer #(
	parameter int MAX_OBJECTS = 7
) (
	input  wire        clk,
	input  wire        arst_n,
	ptf_msg_if.sink    msg,
	ptf_byte_if.source tx
);
	import ptf_pkg::*;

	localparam int         NCELLS  = 11 + 4 * MAX_OBJECTS;
	localparam logic [2:0] MAX_CNT = 3'(MAX_OBJECTS);

	cell_t             cells [NCELLS+1];
	logic [NCELLS-1:0] vld_vec;
	cell_ctl_t         ctl;
	logic [2:0]        cnt;
	obj_arr_t          objs;

	assign cnt  = (msg.num_objs > MAX_CNT) ? MAX_CNT : msg.num_objs;
	assign objs = {msg.data_object_6, msg.data_object_5, msg.data_object_4,
	               msg.data_object_3, msg.data_object_2, msg.data_object_1,
	               msg.data_object_0};

	assign msg.ready = !cells[0].vld;
	assign ctl.load  = msg.valid && msg.ready;
	assign ctl.shift = tx.valid && tx.ready;

	assign cells[NCELLS] = '0;

	for (genvar i = 0; i < NCELLS; i++) begin : g_cell
		ptf_cell #(.IDX(i)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.header    (msg.header),
			.cnt       (cnt),
			.objs      (objs),
			.from_next (cells[i+1]),
			.cell_out  (cells[i])
		);
		assign vld_vec[i] = cells[i].vld;
	end

	assign tx.valid     = cells[0].vld;
	assign tx.tok_byte  = cells[0].data;
	assign tx.last_byte = cells[0].last;

	// a frame always sits packed against the head of the chain
	a_contig: assert property (@(posedge clk) disable iff (!arst_n)
		((vld_vec >> 1) & ~vld_vec) == '0)
		else $error("cell chain has a gap");

	a_first_sop: assert property (@(posedge clk) disable iff (!arst_n)
		(msg.valid && msg.ready) |=> (tx.valid && tx.tok_byte == TOK_SOP1))
		else $error("frame does not start with sop1");

	a_last_txon: assert property (@(posedge clk) disable iff (!arst_n)
		(tx.valid && tx.last_byte) |-> (tx.tok_byte == TOK_TXON && vld_vec[NCELLS-1:1] == '0))
		else $error("last byte is not a lone txon");

	a_empty_after: assert property (@(posedge clk) disable iff (!arst_n)
		(tx.valid && tx.ready && tx.last_byte) |=> (vld_vec == '0 && msg.ready))
		else $error("chain not empty after last byte");

endmodule
`default_nettype wire

[dv/ptf_frame_checker.sv]
`timescale 1ns / 100ps
// frame checker: predicts the fifo token stream of each message request and compares it
module ptf_frame_checker #(
	parameter int MAX_OBJECTS = 7
) (
	input  wire clk,
	input  wire arst_n,
	ptf_msg_if  msg,
	ptf_byte_if tx,
	output int  mismatches,
	output int  bytes_due
);
	import ptf_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} fifo_entry_t;

	fifo_entry_t fifo_due_q[$];

	// own copy of what the framer holds for the last message
	logic [15:0] held_header;
	logic [2:0]  held_count;
	obj_arr_t    held_objects;

	task automatic push_token(input logic [7:0] data, input logic last);
		fifo_due_q.push_back('{data: data, last: last});
	endtask

	task automatic frame_message(input logic [15:0] header, input logic [2:0] count,
		input obj_arr_t objects);
		int used;
		used = count;
		if (used > MAX_OBJECTS)
			used = MAX_OBJECTS;
		if (used > OBJ_SLOTS)
			used = OBJ_SLOTS;
		held_header  = header;
		held_count   = 3'(used);
		held_objects = objects;
		push_token(TOK_SOP1, 1'b0);
		push_token(TOK_SOP1, 1'b0);
		push_token(TOK_SOP1, 1'b0);
		push_token(TOK_SOP2, 1'b0);
		push_token(TOK_PACKSYM | 8'(used * 4 + 2), 1'b0);
		push_token(held_header[7:0], 1'b0);
		push_token(held_header[15:8], 1'b0);
		for (int k = 0; k < held_count; k++) begin
			for (int b = 0; b < 4; b++)
				push_token(held_objects[k][8*b +: 8], 1'b0);
		end
		push_token(TOK_JAM_CRC, 1'b0);
		push_token(TOK_EOP, 1'b0);
		push_token(TOK_TXOFF, 1'b0);
		push_token(TOK_TXON, 1'b1);
	endtask

	initial begin
		mismatches = 0;
		bytes_due  = 0;
		held_header  = '0;
		held_count   = '0;
		held_objects = '0;
	end

	always @(posedge clk) begin
		fifo_entry_t want;
		if (arst_n) begin
			// check the byte first: a request taken on this edge only yields later bytes
			if (tx.valid && tx.ready) begin
				if (fifo_due_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected byte %02h last %0b", $realtime,
							tx.tok_byte, tx.last_byte);
				end else begin
					want = fifo_due_q.pop_front();
					if (tx.tok_byte !== want.data) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: tok_byte expected %02h actual %02h", $realtime,
								want.data, tx.tok_byte);
					end
					if (tx.last_byte !== want.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: last_byte expected %0b actual %0b", $realtime,
								want.last, tx.last_byte);
					end
				end
			end
			if (msg.valid && msg.ready)
				frame_message(msg.header, msg.num_objs,
					{msg.data_object_6, msg.data_object_5, msg.data_object_4,
					 msg.data_object_3, msg.data_object_2, msg.data_object_1,
					 msg.data_object_0});
			bytes_due = fifo_due_q.size();
		end
	end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// testbench top: clock, reset, message and sink stimulus, and the final verdict
module tb_top;
	import ptf_pkg::*;

	localparam int MAX_OBJ    = 7;
	localparam int RAND_MSGS  = 95;
	localparam int CYCLE_CAP  = 2000000;

	logic clk;
	logic arst_n;
	bit   quiet;
	int   cycles;
	int   mismatches;
	int   bytes_due;

	ptf_msg_if  msg_ch ();
	ptf_byte_if tx_ch ();

	pd_tx_fifo_token_framer #(.MAX_OBJECTS(MAX_OBJ)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch),
		.tx     (tx_ch)
	);

	ptf_frame_checker #(.MAX_OBJECTS(MAX_OBJ)) frame_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.msg        (msg_ch),
		.tx         (tx_ch),
		.mismatches (mismatches),
		.bytes_due  (bytes_due)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// mostly back to back, some short gaps, now and then a long one
	function automatic int pick_gap();
		int roll;
		if (quiet)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_message(input logic [15:0] header, input logic [2:0] count,
		input obj_arr_t objects);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			msg_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		msg_ch.valid         <= 1'b1;
		msg_ch.header        <= header;
		msg_ch.num_objs      <= count;
		msg_ch.data_object_0 <= objects[0];
		msg_ch.data_object_1 <= objects[1];
		msg_ch.data_object_2 <= objects[2];
		msg_ch.data_object_3 <= objects[3];
		msg_ch.data_object_4 <= objects[4];
		msg_ch.data_object_5 <= objects[5];
		msg_ch.data_object_6 <= objects[6];
		do @(posedge clk); while (!msg_ch.ready);
	endtask

	// first let the checker see the last accepted request, then wait until no bytes are due
	task automatic drain_frames();
		msg_ch.valid <= 1'b0;
		@(posedge clk);
		while (bytes_due != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_CAP) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// sink side: ready runs broken by stalls
	initial begin
		int run;
		int stall;
		tx_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			run = $urandom_range(1, 12);
			tx_ch.ready <= 1'b1;
			repeat (run) @(posedge clk);
			stall = pick_gap();
			if (stall > 0) begin
				tx_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	initial begin
		obj_arr_t objs;
		logic [2:0] count;
		cycles = 0;
		quiet  = 1'b0;
		arst_n               <= 1'b0;
		msg_ch.valid         <= 1'b0;
		msg_ch.header        <= '0;
		msg_ch.num_objs      <= '0;
		msg_ch.data_object_0 <= '0;
		msg_ch.data_object_1 <= '0;
		msg_ch.data_object_2 <= '0;
		msg_ch.data_object_3 <= '0;
		msg_ch.data_object_4 <= '0;
		msg_ch.data_object_5 <= '0;
		msg_ch.data_object_6 <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// field extremes, and unused objects that must not show up
		send_message(16'h0000, 3'd0, '0);
		send_message(16'hFFFF, 3'd0, '1);
		send_message(16'h1234, 3'd1, {{6{32'hDEADBEEF}}, 32'h04030201});
		for (int c = 1; c <= MAX_OBJ; c++) begin
			for (int k = 0; k < OBJ_SLOTS; k++)
				objs[k] = $urandom;
			send_message(16'($urandom), 3'(c), objs);
		end
		send_message(16'hFFFF, 3'd7, '1);
		send_message(16'h0000, 3'd7, '0);
		send_message(16'hA55A, 3'd7, {32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA,
			32'h55555555, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA});
		send_message(16'h5AA5, 3'd6, {32'hFFFFFFFF, 32'h55555555, 32'hAAAAAAAA,
			32'h55555555, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA});
		drain_frames();

		for (int i = 0; i < RAND_MSGS; i++) begin
			// a stretch with both sides running flat out
			quiet = (i >= 40 && i < 60);
			if (i == 75)
				drain_frames();
			count = 3'($urandom_range(0, 7));
			for (int k = 0; k < OBJ_SLOTS; k++)
				objs[k] = $urandom;
			send_message(16'($urandom), count, objs);
		end
		quiet = 1'b0;
		drain_frames();
		repeat (20) @(posedge clk);

		if (mismatches == 0 && bytes_due == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[filelist.f]
rtl/core/ptf_pkg.sv
rtl/core/ptf_msg_if.sv
rtl/core/ptf_byte_if.sv
rtl/core/ptf_cell.sv
rtl/core/pd_tx_fifo_token_framer.sv
dv/ptf_frame_checker.sv
dv/tb_top.sv
